@@ rtl/core/bfg_pkg.sv @@
// Shared constants, codes and types for the grayscale bilateral filter.
// No dependencies; the top, front end, queue, engine and bench import this package.
`timescale 1ns / 1ps
package bfg_pkg;

  localparam int MAX_RADIUS_DEF  = 3;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int MAX_HEIGHT      = 1024;
  localparam int RANGE_DEPTH     = 256;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_BITS        = 11;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int POS_BITS        = 10;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [1:0]          RADIUS_RESET = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic [1:0] OP_LOAD_SPATIAL = 2'd0;
  localparam logic [1:0] OP_LOAD_RANGE   = 2'd1;
  localparam logic [1:0] OP_PIXEL        = 2'd2;

  typedef enum logic [1:0] {
    KIND_SPATIAL,
    KIND_RANGE,
    KIND_PIXEL
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CENTRE,
    BK_TAPS,
    BK_DRAIN,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

@@ rtl/core/bfg_in_if.sv @@
// Input request channel: weight loads and pixels with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface bfg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  table_index;
  logic [15:0] weight_value;
  logic [7:0]  pixel_value;

  modport source(output valid, operation, table_index, weight_value, pixel_value,
                 input ready);
  modport sink(input valid, operation, table_index, weight_value, pixel_value,
               output ready);
endinterface

@@ rtl/core/bfg_out_if.sv @@
// Output request channel: filtered pixel with its position, valid/ready.
// No dependencies.
`timescale 1ns / 1ps
interface bfg_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic [7:0] filtered_value;

  modport source(output valid, out_row, out_col, filtered_value, input ready);
  modport sink(input valid, out_row, out_col, filtered_value, output ready);
endinterface

@@ rtl/core/bilateral_filter_gray.sv @@
// Top level of the grayscale bilateral filter: front end, queue, engine.
// Depends on bfg_pkg, bfg_in_if, bfg_out_if, bfg_front, bfg_queue, bfg_back.
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   operation, table_index, weight_value, pixel_value
//   out_ch    out  valid/ready   out_row, out_col, filtered_value
//   cfg       in   cfg_we        cfg_index, cfg_data
//
// Weight loads and border pixels are taken in the engine's idle state; an interior
// pixel goes through the centre read, the single shared multiply-accumulate walking
// the window taps one per cycle, a four-stage product pipe and an 8-step divide.
// rst is synchronous; tables and line store are not cleared and hold no valid
// bits. A stalled output holds the engine once its next result is ready; the queue accepts requests until full.
`timescale 1ns / 1ps
module bilateral_filter_gray import bfg_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  bfg_in_if.sink                    in_ch,
  bfg_out_if.source                 out_ch
);

  localparam int NL = 2 * MAX_RADIUS + 1;
  localparam int SB = $clog2(NL);
  localparam int CB = $clog2(MAX_WIDTH);

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             idx;
    logic [WEIGHT_BITS-1:0] wv;
    logic [7:0]             pix;
    logic [SB-1:0]          wslot;
    logic [CB-1:0]          wcol;
    logic [SB-1:0]          top_slot;
    logic [SB-1:0]          centre_slot;
    logic [CB-1:0]          left;
    logic [1:0]             radius;
    logic                   emit;
    logic [POS_BITS-1:0]    orow;
    logic [POS_BITS-1:0]    ocol;
  } entry_t;

  logic   push_valid, push_ready, q_valid, pop;
  entry_t push_data, q_data;

  bfg_front #(
    .MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH),
    .WEIGHT_BITS(WEIGHT_BITS), .entry_t(entry_t)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch),
    .push_ready(push_ready), .push_valid(push_valid), .push_data(push_data)
  );

  bfg_queue #(
    .DEPTH(QUEUE_DEPTH), .entry_t(entry_t)
  ) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(q_valid), .pop(pop), .pop_data(q_data)
  );

  bfg_back #(
    .MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH),
    .WEIGHT_BITS(WEIGHT_BITS), .entry_t(entry_t)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_data(q_data), .pop(pop),
    .out_ch(out_ch)
  );

endmodule

@@ rtl/core/bfg_front.sv @@
// Front end: configuration registers, request classification, raster position.
// Depends on bfg_pkg and bfg_in_if; pushes work entries into bfg_queue.
`timescale 1ns / 1ps
module bfg_front import bfg_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter type entry_t    = logic
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  bfg_in_if.sink                    in_ch,
  input  logic                      push_ready,
  output logic                      push_valid,
  output entry_t                    push_data
);

  localparam int NL   = 2 * MAX_RADIUS + 1;
  localparam int NT   = NL * NL;
  localparam int SB   = $clog2(NL);
  localparam int CB   = $clog2(MAX_WIDTH);
  localparam int XW   = (CB + 1 > CFG_BITS) ? CB + 1 : CFG_BITS;
  localparam int OW   = (CB > POS_BITS) ? CB : POS_BITS;
  localparam int RLIM = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
  localparam int EW   = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

  logic [CFG_BITS-1:0] image_width, image_height;
  logic [1:0]          window_radius;
  logic [POS_BITS-1:0] row;
  logic [CB-1:0]       col;
  logic [SB-1:0]       slot;

  logic [XW-1:0]         wcl, col_p1;
  logic [CFG_BITS-1:0]   hcl, row_p1;
  logic [1:0]            r;
  logic [2:0]            r2;
  logic [SB:0]           top_tmp, ctr_tmp;
  logic [OW-1:0]         ocol_full;
  logic [EW-1:0]         wext;
  logic                  accept, keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      window_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_WINDOW_RADIUS: window_radius <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) wcl = XW'(1);
    else if (XW'(image_width) > XW'(MAX_WIDTH)) wcl = XW'(MAX_WIDTH);
    else wcl = XW'(image_width);
    if (image_height == '0) hcl = CFG_BITS'(1);
    else if (image_height > CFG_BITS'(MAX_HEIGHT)) hcl = CFG_BITS'(MAX_HEIGHT);
    else hcl = image_height;
    if (window_radius == '0) r = 2'd1;
    else if ({1'b0, window_radius} > 3'(RLIM)) r = 2'(RLIM);
    else r = window_radius;
    r2      = {r, 1'b0};
    col_p1  = XW'(col) + XW'(1);
    row_p1  = CFG_BITS'(row) + CFG_BITS'(1);
    top_tmp = (SB + 1)'(slot) + (SB + 1)'(NL) - (SB + 1)'(r2);
    if (top_tmp >= (SB + 1)'(NL)) top_tmp = top_tmp - (SB + 1)'(NL);
    ctr_tmp = top_tmp + (SB + 1)'(r);
    if (ctr_tmp >= (SB + 1)'(NL)) ctr_tmp = ctr_tmp - (SB + 1)'(NL);
    ocol_full = OW'(col) - OW'(r);
    wext = EW'(in_ch.weight_value);
  end

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    case (in_ch.operation)
      OP_LOAD_SPATIAL: keep = in_ch.table_index < 8'(NT);
      OP_LOAD_RANGE:   keep = 1'b1;
      OP_PIXEL:        keep = 1'b1;
      default:         keep = 1'b0;
    endcase
  end

  assign push_valid = accept && keep;

  always_comb begin
    case (in_ch.operation)
      OP_LOAD_SPATIAL: push_data.kind = KIND_SPATIAL;
      OP_LOAD_RANGE:   push_data.kind = KIND_RANGE;
      default:         push_data.kind = KIND_PIXEL;
    endcase
    push_data.idx         = in_ch.table_index;
    push_data.wv          = wext[WEIGHT_BITS-1:0];
    push_data.pix         = in_ch.pixel_value;
    push_data.wslot       = slot;
    push_data.wcol        = col;
    push_data.top_slot    = top_tmp[SB-1:0];
    push_data.centre_slot = ctr_tmp[SB-1:0];
    push_data.left        = col - CB'(r2);
    push_data.radius      = r;
    push_data.emit        = (row >= POS_BITS'(r2)) && (OW'(col) >= OW'(r2));
    push_data.orow        = row - POS_BITS'(r);
    push_data.ocol        = ocol_full[POS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      col  <= '0;
      slot <= '0;
    end else if (accept && in_ch.operation == OP_PIXEL) begin
      if (col_p1 >= wcl) begin
        col <= '0;
        if (row_p1 >= hcl) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row_p1[POS_BITS-1:0];
          slot <= (slot == SB'(NL - 1)) ? '0 : slot + SB'(1);
        end
      end else begin
        col <= col_p1[CB-1:0];
      end
    end
  end

endmodule

@@ rtl/core/bfg_queue.sv @@
// Short FIFO of work entries between the front end and the filter engine.
// Depends on bfg_pkg for its default depth.
`timescale 1ns / 1ps
module bfg_queue import bfg_pkg::*; #(
  parameter int  DEPTH   = QUEUE_DEPTH,
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop,
  output entry_t pop_data
);

  localparam int PB = $clog2(DEPTH);

  entry_t        slots [DEPTH];
  logic [PB-1:0] head, tail;
  logic [PB:0]   count;
  logic          do_push, do_pop;

  assign push_ready = count != (PB + 1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[tail] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= (tail == PB'(DEPTH - 1)) ? '0 : tail + PB'(1);
      if (do_pop)  head <= (head == PB'(DEPTH - 1)) ? '0 : head + PB'(1);
      if (do_push && !do_pop)      count <= count + (PB + 1)'(1);
      else if (do_pop && !do_push) count <= count - (PB + 1)'(1);
    end
  end

endmodule

@@ rtl/core/bfg_back.sv @@
// Filter engine: weight tables, line store, shared multiply-accumulate,
// restoring divider and output register. Depends on bfg_pkg and bfg_out_if.
`timescale 1ns / 1ps
module bfg_back import bfg_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter type entry_t    = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  entry_t q_data,
  output logic   pop,
  bfg_out_if.source out_ch
);

  localparam int NL  = 2 * MAX_RADIUS + 1;
  localparam int NT  = NL * NL;
  localparam int SB  = $clog2(NL);
  localparam int TB  = $clog2(NT);
  localparam int LA  = $clog2(NL * MAX_WIDTH);
  localparam int PWB = 2 * WEIGHT_BITS;
  localparam int SWB = PWB + $clog2(NT);
  localparam int SPB = SWB + 8;
  localparam logic [LA-1:0] MWA = LA'(MAX_WIDTH);

  logic [7:0]             line_mem [NL * MAX_WIDTH];
  logic [WEIGHT_BITS-1:0] sp_mem [NT];
  logic [WEIGHT_BITS-1:0] rg_mem [RANGE_DEPTH];

  back_state_t state, state_next;
  entry_t      e;
  logic [SB-1:0] dr, dc, side_m1;
  logic [TB-1:0] tap;
  logic [LA-1:0] base, line_raddr, line_waddr;
  logic [7:0]    centre, line_q, p2, p3, diff;
  logic [WEIGHT_BITS-1:0] sp_q, ws2, rg_q;
  logic [PWB-1:0]     prod_w;
  logic [PWB+7:0]     prod_pw;
  logic [SWB-1:0]     sum_w;
  logic [SPB-1:0]     sum_pw, rem, dsh;
  logic [7:0]         quo;
  logic [2:0]         step;
  logic v1, c1, v2, v3, v4;
  logic issue, line_we, sp_we, rg_we, load_out, taps_last;

  assign side_m1   = SB'({e.radius, 1'b0});
  assign taps_last = (dr == side_m1) && (dc == side_m1);
  assign diff      = (line_q > centre) ? line_q - centre : centre - line_q;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (q_valid && q_data.kind == KIND_PIXEL && q_data.emit)
                   state_next = BK_CENTRE;
      BK_CENTRE: state_next = BK_TAPS;
      BK_TAPS:   if (taps_last) state_next = BK_DRAIN;
      BK_DRAIN:  if (!v1 && !v2 && !v3 && !v4) state_next = BK_DIV;
      BK_DIV:    if (step == 3'd7) state_next = BK_DONE;
      BK_DONE:   if (!out_ch.valid || out_ch.ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    line_we  = 1'b0;
    sp_we    = 1'b0;
    rg_we    = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: begin
        pop     = q_valid;
        line_we = q_valid && q_data.kind == KIND_PIXEL;
        sp_we   = q_valid && q_data.kind == KIND_SPATIAL;
        rg_we   = q_valid && q_data.kind == KIND_RANGE;
      end
      BK_CENTRE: issue = 1'b1;
      BK_TAPS:   issue = 1'b1;
      BK_DONE:   load_out = !out_ch.valid || out_ch.ready;
      default: ;
    endcase
  end

  assign line_waddr = LA'(q_data.wslot) * MWA + LA'(q_data.wcol);

  always_comb begin
    if (state == BK_CENTRE)
      line_raddr = LA'(e.centre_slot) * MWA + LA'(e.left) + LA'(e.radius);
    else
      line_raddr = base + LA'(e.left) + LA'(dc);
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_waddr] <= q_data.pix;
    line_q <= line_mem[line_raddr];
  end

  always_ff @(posedge clk) begin
    if (sp_we) sp_mem[TB'(q_data.idx)] <= q_data.wv;
    sp_q <= sp_mem[tap];
  end

  always_ff @(posedge clk) begin
    if (rg_we) rg_mem[q_data.idx] <= q_data.wv;
    rg_q <= rg_mem[diff];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      state <= state_next;
      v1 <= issue;
      v2 <= v1 && !c1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    c1 <= state == BK_CENTRE;
    if (pop) begin
      e      <= q_data;
      dr     <= '0;
      dc     <= '0;
      tap    <= '0;
      base   <= LA'(q_data.top_slot) * MWA;
      sum_w  <= '0;
      sum_pw <= '0;
    end
    if (state == BK_TAPS) begin
      tap <= tap + TB'(1);
      if (dc == side_m1) begin
        dc <= '0;
        dr <= dr + SB'(1);
        base <= (base == LA'(NL - 1) * MWA) ? '0 : base + MWA;
      end else begin
        dc <= dc + SB'(1);
      end
    end
    if (v1 && c1) centre <= line_q;
    p2     <= line_q;
    ws2    <= sp_q;
    prod_w <= ws2 * rg_q;
    p3     <= p2;
    prod_pw <= prod_w * p3;
    if (v3) sum_w  <= sum_w + SWB'(prod_w);
    if (v4) sum_pw <= sum_pw + SPB'(prod_pw);
    if (state == BK_DRAIN) begin
      rem  <= sum_pw;
      dsh  <= SPB'({sum_w, 7'b0});
      step <= '0;
    end
    if (state == BK_DIV) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[6:0], 1'b1};
      end else begin
        quo <= {quo[6:0], 1'b0};
      end
      dsh  <= dsh >> 1;
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.out_row        <= e.orow;
      out_ch.out_col        <= e.ocol;
      out_ch.filtered_value <= (sum_w == '0) ? centre : quo;
    end
  end

endmodule

@@ bench/tb_bilateral_filter_gray.sv @@
// Testbench for bilateral_filter_gray: directed table, then random frames at many sizes.
// Checks every result against an in-bench filter predictor or a typed directed-table value;
// depends on bfg_pkg and the bfg_in_if / bfg_out_if interfaces of the block.
`timescale 1ns / 1ps
module tb_bilateral_filter_gray;
  import bfg_pkg::*;

  localparam int LINES       = 2 * MAX_RADIUS_DEF + 1;
  localparam int SP_DEPTH    = LINES * LINES;
  localparam int MAX_GAP     = 13;
  localparam int SETTLE      = 150;
  localparam int STALL_LIM   = 5000;
  localparam int ITEM_TARGET = 1850;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] value;
  } pix_out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [15:0] wv;
    logic [7:0]  pix;
    bit          typed;
    pix_out_t    result;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  bfg_in_if  in_ch ();
  bfg_out_if out_ch ();

  bilateral_filter_gray DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic [7:0]  lines_mem [LINES][MAX_WIDTH_DEF];
  logic [15:0] sp_w [SP_DEPTH];
  logic [15:0] rg_w [RANGE_DEPTH];
  int unsigned cur_row, cur_col;
  logic [10:0] reg_width, reg_height;
  logic [1:0]  reg_radius;

  pix_out_t filtered_q [$];
  int errors;
  int idle_cnt;
  bit calm;
  int sent_items;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit filter_step(logic [1:0] op, logic [7:0] idx, logic [15:0] wv,
                                     logic [7:0] pix, output pix_out_t res);
    int unsigned w, h, r, top, left;
    logic [7:0] centre, p, diff;
    longint unsigned wt, sum_w, sum_pw;
    bit hit;
    w = clampu(32'(reg_width), 1, MAX_WIDTH_DEF);
    h = clampu(32'(reg_height), 1, MAX_HEIGHT);
    r = clampu(32'(reg_radius), 1, MAX_RADIUS_DEF);
    sum_w = 0;
    sum_pw = 0;
    hit = 0;
    res = '0;
    if (op == OP_LOAD_SPATIAL) begin
      if (idx < SP_DEPTH) sp_w[idx] = wv;
      return 0;
    end
    if (op == OP_LOAD_RANGE) begin
      rg_w[idx] = wv;
      return 0;
    end
    if (op != OP_PIXEL) return 0;
    lines_mem[cur_row % LINES][cur_col] = pix;
    if (cur_row >= 2 * r && cur_col >= 2 * r) begin
      top = cur_row - 2 * r;
      left = cur_col - 2 * r;
      centre = lines_mem[(top + r) % LINES][left + r];
      for (int dr = 0; dr <= 2 * r; dr++) begin
        for (int dc = 0; dc <= 2 * r; dc++) begin
          p = lines_mem[(top + dr) % LINES][left + dc];
          diff = (p > centre) ? p - centre : centre - p;
          wt = longint'(sp_w[dr * (2 * r + 1) + dc]) * longint'(rg_w[diff]);
          sum_w += wt;
          sum_pw += wt * p;
        end
      end
      res.row = 10'(cur_row - r);
      res.col = 10'(cur_col - r);
      res.value = (sum_w == 0) ? centre : 8'(sum_pw / sum_w);
      hit = 1;
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
    return hit;
  endfunction

  task automatic report(string what, pix_out_t got, pix_out_t want);
    errors++;
    $display("mismatch %s: got r%0d c%0d v%0d, want r%0d c%0d v%0d at %0t", what,
             got.row, got.col, got.value, want.row, want.col, want.value, $realtime);
  endtask

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send(logic [1:0] op, logic [7:0] idx, logic [15:0] wv, logic [7:0] pix,
                      bit typed = 0, pix_out_t typed_res = '0);
    int gap;
    pix_out_t res;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.table_index <= idx;
    in_ch.weight_value <= wv;
    in_ch.pixel_value <= pix;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
    if (filter_step(op, idx, wv, pix, res)) filtered_q.push_back(typed ? typed_res : res);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) reg_width = data;
    else if (idx == REG_IMAGE_HEIGHT) reg_height = data;
    else if (idx == REG_WINDOW_RADIUS) reg_radius = data[1:0];
  endtask

  // drain outstanding results, then let queued no-result requests finish
  task automatic settle_and_configure(logic [10:0] w, logic [10:0] h, logic [1:0] r);
    in_ch.valid <= 1'b0;
    while (filtered_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RADIUS, {9'($urandom_range(0, 511)), r});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_tables(bit random_fill);
    for (int i = 0; i < SP_DEPTH; i++)
      send(OP_LOAD_SPATIAL, 8'(i), random_fill ? 16'($urandom) : 16'd0, 8'($urandom));
    for (int i = 0; i < RANGE_DEPTH; i++)
      send(OP_LOAD_RANGE, 8'(i), random_fill ? 16'($urandom_range(1, 65535)) : 16'd1,
           8'($urandom));
  endtask

  task automatic run_frames(int frames);
    int unsigned w, h;
    logic [7:0] base, pv;
    w = clampu(32'(reg_width), 1, MAX_WIDTH_DEF);
    h = clampu(32'(reg_height), 1, MAX_HEIGHT);
    base = 8'($urandom);
    for (int n = 0; n < frames * w * h; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: send(OP_LOAD_SPATIAL, 8'($urandom), 16'($urandom), 8'($urandom));
          1: send(OP_LOAD_RANGE, 8'($urandom), 16'($urandom), 8'($urandom));
          default: send(OP_RESERVED, 8'($urandom), 16'($urandom), 8'($urandom));
        endcase
      end
      if ($urandom_range(0, 1)) pv = 8'($urandom);
      else pv = base + 8'($urandom_range(0, 16)) - 8'd8;
      send(OP_PIXEL, 8'($urandom), 16'($urandom), pv);
      if ($urandom_range(0, 99) == 0) calm = ~calm;
    end
  endtask

  dir_row_t dir_tab [22];

  initial begin
    pix_out_t none;
    none = '0;
    // all spatial weights zero: zero weight sum, result is the centre pixel
    dir_tab[0]  = '{OP_RESERVED, 8'd7, 16'hFFFF, 8'hFF, 0, none};
    dir_tab[1]  = '{OP_LOAD_SPATIAL, 8'd200, 16'hFFFF, 8'd0, 0, none};
    dir_tab[2]  = '{OP_LOAD_RANGE, 8'd255, 16'hFFFF, 8'd0, 0, none};
    dir_tab[3]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd0, 0, none};
    dir_tab[4]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[5]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd17, 0, none};
    dir_tab[6]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[7]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd128, 0, none};
    dir_tab[8]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd0, 0, none};
    dir_tab[9]  = '{OP_PIXEL, 8'd0, 16'd0, 8'd1, 0, none};
    dir_tab[10] = '{OP_PIXEL, 8'd0, 16'd0, 8'd2, 0, none};
    dir_tab[11] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 1, '{10'd1, 10'd1, 8'd128}};
    // only the centre tap weighted: result is the centre pixel
    dir_tab[12] = '{OP_LOAD_SPATIAL, 8'd4, 16'hFFFF, 8'd0, 0, none};
    dir_tab[13] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[14] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[15] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[16] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[17] = '{OP_PIXEL, 8'd0, 16'd0, 8'd7, 0, none};
    dir_tab[18] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[19] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[20] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 0, none};
    dir_tab[21] = '{OP_PIXEL, 8'd0, 16'd0, 8'd255, 1, '{10'd1, 10'd1, 8'd7}};

    errors = 0;
    calm = 0;
    sent_items = 0;
    cur_row = 0;
    cur_col = 0;
    reg_width = WIDTH_RESET;
    reg_height = HEIGHT_RESET;
    reg_radius = RADIUS_RESET;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.table_index = '0;
    in_ch.weight_value = '0;
    in_ch.pixel_value = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    settle_and_configure(11'd3, 11'd3, 2'd1);
    load_tables(0);
    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].wv, dir_tab[i].pix,
           dir_tab[i].typed, dir_tab[i].result);
    load_tables(1);

    // extremes: wide row, tall narrow frame, sizes and radius below range, largest radius
    calm = 1;
    settle_and_configure(11'd160, 11'd3, 2'd1);
    run_frames(1);
    settle_and_configure(11'd1, 11'd40, 2'd0);
    run_frames(1);
    calm = 0;
    settle_and_configure(11'd0, 11'd0, 2'd3);
    run_frames(3);
    settle_and_configure(11'd9, 11'd8, 2'd3);
    run_frames(1);

    while (sent_items < ITEM_TARGET) begin
      settle_and_configure(11'($urandom_range(1, 12)), 11'($urandom_range(1, 10)),
                           2'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) load_tables(1);
      run_frames($urandom_range(1, 2));
    end

    in_ch.valid <= 1'b0;
    while (filtered_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // result side: random stalls, compare each accepted result with the oldest expectation
  initial begin
    pix_out_t got;
    int stall;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.out_row, out_ch.out_col, out_ch.filtered_value};
      if (filtered_q.size() == 0) report("unexpected", got, '0);
      else if (got != filtered_q[0]) report("field", got, filtered_q.pop_front());
      else void'(filtered_q.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIM) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
